FILE: rtl/bdslp_pkg.sv
// ----------------------------------------------------------------------------
// bdslp_pkg
// Shared types and constants for the two-button debounce and press detector.
// ----------------------------------------------------------------------------
package bdslp_pkg;

  // Configuration register layout
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TICKS = 1'd1;

  localparam logic [CFG_W-1:0] DEBOUNCE_TICKS_RST   = 16'd30;
  localparam logic [CFG_W-1:0] LONG_PRESS_TICKS_RST = 16'd700;

  // Stream payload widths (fields padded to whole bytes)
  localparam int unsigned S_DATA_W = 8;
  localparam int unsigned M_DATA_W = 8;

  // Per-button results for one tick
  typedef struct packed {
    logic short_press;
    logic long_press;
    logic down;
  } btn_evt_t;

endpackage

FILE: rtl/bdslp_button.sv
// ----------------------------------------------------------------------------
// bdslp_button
// Debounce, hold timing and short/long press decision for one button.
// ----------------------------------------------------------------------------
module bdslp_button #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic                         raw,
  input  logic [bdslp_pkg::CFG_W-1:0]  debounce_ticks,
  input  logic [bdslp_pkg::CFG_W-1:0]  long_press_ticks,
  output bdslp_pkg::btn_evt_t          evt
);

  localparam int unsigned CMP_W =
    (COUNTER_WIDTH > bdslp_pkg::CFG_W) ? COUNTER_WIDTH : bdslp_pkg::CFG_W;
  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);

  logic                     last_raw;
  logic                     stable;
  logic [COUNTER_WIDTH-1:0] change_cnt;
  logic [COUNTER_WIDTH-1:0] hold_cnt;
  logic                     press_timing;
  logic                     long_fired;

  logic                     stable_next;
  logic [COUNTER_WIDTH-1:0] change_cnt_next;
  logic [COUNTER_WIDTH-1:0] hold_cnt_next;
  logic                     press_timing_next;
  logic                     long_fired_next;
  logic                     adopt;
  logic                     short_hit;
  logic                     long_hit;

  // Work out the next state and this tick's pulses
  always_comb begin
    if (raw != last_raw) begin
      change_cnt_next = '0;
    end else if (change_cnt == CNT_MAX) begin
      change_cnt_next = change_cnt;
    end else begin
      change_cnt_next = change_cnt + CNT_ONE;
    end

    if (press_timing && (hold_cnt != CNT_MAX)) begin
      hold_cnt_next = hold_cnt + CNT_ONE;
    end else begin
      hold_cnt_next = hold_cnt;
    end

    stable_next       = stable;
    press_timing_next = press_timing;
    long_fired_next   = long_fired;
    short_hit         = 1'b0;
    long_hit          = 1'b0;

    // Adopt the raw level once it has stayed put long enough
    adopt = (CMP_W'(change_cnt_next) > CMP_W'(debounce_ticks)) && (stable != raw);
    if (adopt) begin
      stable_next = raw;
      if (!raw) begin
        hold_cnt_next     = '0;
        press_timing_next = 1'b1;
        long_fired_next   = 1'b0;
      end else begin
        short_hit         = press_timing && !long_fired;
        press_timing_next = 1'b0;
        long_fired_next   = 1'b0;
      end
    end

    // Fire the long press once per hold
    if (!stable_next && press_timing_next && !long_fired_next &&
        (CMP_W'(hold_cnt_next) >= CMP_W'(long_press_ticks))) begin
      long_fired_next = 1'b1;
      long_hit        = 1'b1;
    end

    evt.short_press = short_hit;
    evt.long_press  = long_hit;
    evt.down        = !stable_next;
  end

  // Advance the button state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw     <= 1'b1;
      stable       <= 1'b1;
      change_cnt   <= '0;
      hold_cnt     <= '0;
      press_timing <= 1'b0;
      long_fired   <= 1'b0;
    end else if (advance) begin
      last_raw     <= raw;
      stable       <= stable_next;
      change_cnt   <= change_cnt_next;
      hold_cnt     <= hold_cnt_next;
      press_timing <= press_timing_next;
      long_fired   <= long_fired_next;
    end
  end

endmodule

FILE: rtl/button_debounce_short_long_press.sv
// ----------------------------------------------------------------------------
// button_debounce_short_long_press
// Two-button debouncer with short and long press pulses.
// ----------------------------------------------------------------------------
// Each input beat is one timebase tick carrying the raw active-low levels of
// the left and right buttons; each tick yields exactly one output beat with
// one-tick short/long press pulses and the debounced down levels. A tick is
// taken every clock cycle while input ready is high, and its result is registered
// in the output register; a second output register lets one more tick be accepted
// while the master side stalls, so input ready drops only when both hold
// results. A raw level is adopted once it stays unchanged for more than
// debounce_ticks ticks; a long press fires once when the hold reaches
// long_press_ticks, and a release gives a short press only if no long press
// fired. Counters are COUNTER_WIDTH bits and saturate. Write the config port
// only while no tick is in flight.
module button_debounce_short_long_press #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port
  input  logic                                 cfg_we,
  input  logic [bdslp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bdslp_pkg::CFG_W-1:0]          cfg_data,
  // Tick input
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [bdslp_pkg::S_DATA_W-1:0]       s_tdata,   // left_raw, right_raw, zero pad
  // Result output
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [bdslp_pkg::M_DATA_W-1:0]       m_tdata    // left_short, left_long,
                                                          // right_short, right_long,
                                                          // left_down, right_down, zero pad
);

  logic [bdslp_pkg::CFG_W-1:0]    debounce_ticks;
  logic [bdslp_pkg::CFG_W-1:0]    long_press_ticks;
  logic                           accept;
  bdslp_pkg::btn_evt_t            left_evt;
  bdslp_pkg::btn_evt_t            right_evt;
  logic [bdslp_pkg::M_DATA_W-1:0] result;
  logic                           out_valid;
  logic [bdslp_pkg::M_DATA_W-1:0] out_data;
  logic                           skid_valid;
  logic [bdslp_pkg::M_DATA_W-1:0] skid_data;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= bdslp_pkg::DEBOUNCE_TICKS_RST;
      long_press_ticks <= bdslp_pkg::LONG_PRESS_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bdslp_pkg::CFG_DEBOUNCE_TICKS:   debounce_ticks   <= cfg_data;
        bdslp_pkg::CFG_LONG_PRESS_TICKS: long_press_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;

  bdslp_button #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_left (
    .clk             (clk),
    .rst             (rst),
    .advance         (accept),
    .raw             (s_tdata[0]),
    .debounce_ticks  (debounce_ticks),
    .long_press_ticks(long_press_ticks),
    .evt             (left_evt)
  );

  bdslp_button #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_right (
    .clk             (clk),
    .rst             (rst),
    .advance         (accept),
    .raw             (s_tdata[1]),
    .debounce_ticks  (debounce_ticks),
    .long_press_ticks(long_press_ticks),
    .evt             (right_evt)
  );

  // Pack the result beat
  assign result = {2'b00,
                   right_evt.down, left_evt.down,
                   right_evt.long_press, right_evt.short_press,
                   left_evt.long_press, left_evt.short_press};

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Move payloads alongside the valid flags
  always_ff @(posedge clk) begin
    if (m_tready || !out_valid) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (accept) begin
      skid_data <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

FILE: sim/press_event_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// press_event_checker
// Watches the config port and both streams of the two-button debouncer,
// predicts the press events and down levels of every tick, and compares each
// result beat against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module press_event_checker #(
  parameter int unsigned CNT_W = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bdslp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdslp_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [bdslp_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [bdslp_pkg::M_DATA_W-1:0]  m_tdata,
  output int                              fail_count,
  output int                              outstanding
);

  localparam int unsigned LEFT  = 0;
  localparam int unsigned RIGHT = 1;
  localparam logic [CNT_W-1:0] CNT_TOP = '1;
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // One result beat, left_short in bit 0
  typedef struct packed {
    logic right_down;
    logic left_down;
    logic right_long;
    logic right_short;
    logic left_long;
    logic left_short;
  } tick_result_t;

  // Timing registers as the block holds them
  logic [bdslp_pkg::CFG_W-1:0] debounce_limit;
  logic [bdslp_pkg::CFG_W-1:0] long_limit;

  // Per-button debounce and press state
  logic             prev_raw    [2];
  logic             settled     [2];
  logic [CNT_W-1:0] quiet_ticks [2];
  logic [CNT_W-1:0] held_ticks  [2];
  logic             timing_on   [2];
  logic             long_done   [2];

  tick_result_t event_q [$];
  int           beat_no;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == CNT_TOP) ? v : v + CNT_ONE;
  endfunction

  // Advance one button by one tick and report its press pulses
  function automatic void advance_button(input int k, input logic raw,
                                         output logic short_ev, output logic long_ev);
    short_ev = 1'b0;
    long_ev  = 1'b0;
    if (raw != prev_raw[k]) begin
      prev_raw[k]    = raw;
      quiet_ticks[k] = '0;
    end else begin
      quiet_ticks[k] = bump(quiet_ticks[k]);
    end
    if (timing_on[k])
      held_ticks[k] = bump(held_ticks[k]);
    // adopt the raw level once it has been quiet long enough
    if (quiet_ticks[k] > debounce_limit && settled[k] != prev_raw[k]) begin
      settled[k] = prev_raw[k];
      if (!settled[k]) begin
        held_ticks[k] = '0;
        timing_on[k]  = 1'b1;
        long_done[k]  = 1'b0;
      end else begin
        short_ev     = timing_on[k] && !long_done[k];
        timing_on[k] = 1'b0;
        long_done[k] = 1'b0;
      end
    end
    if (!settled[k] && timing_on[k] && !long_done[k] && held_ticks[k] >= long_limit) begin
      long_done[k] = 1'b1;
      long_ev      = 1'b1;
    end
  endfunction

  function automatic tick_result_t predict_tick(input logic left_raw, input logic right_raw);
    tick_result_t r;
    advance_button(LEFT, left_raw, r.left_short, r.left_long);
    advance_button(RIGHT, right_raw, r.right_short, r.right_long);
    r.left_down  = !settled[LEFT];
    r.right_down = !settled[RIGHT];
    return r;
  endfunction

  always @(posedge clk) begin
    tick_result_t want;
    tick_result_t got;
    if (rst) begin
      debounce_limit = bdslp_pkg::DEBOUNCE_TICKS_RST;
      long_limit     = bdslp_pkg::LONG_PRESS_TICKS_RST;
      for (int k = 0; k < 2; k++) begin
        prev_raw[k]    = 1'b1;
        settled[k]     = 1'b1;
        quiet_ticks[k] = '0;
        held_ticks[k]  = '0;
        timing_on[k]   = 1'b0;
        long_done[k]   = 1'b0;
      end
      event_q.delete();
      beat_no = 0;
    end else begin
      // track register writes
      if (cfg_we) begin
        if (cfg_index == bdslp_pkg::CFG_DEBOUNCE_TICKS)
          debounce_limit = cfg_data;
        else if (cfg_index == bdslp_pkg::CFG_LONG_PRESS_TICKS)
          long_limit = cfg_data;
      end
      // predict every accepted tick
      if (s_tvalid && s_tready)
        event_q.push_back(predict_tick(s_tdata[0], s_tdata[1]));
      // compare every result beat with the oldest prediction
      if (m_tvalid && m_tready) begin
        got = tick_result_t'(m_tdata[5:0]);
        if (event_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("beat %0d: result with no tick outstanding, got %06b", beat_no, got);
        end else begin
          want = event_q.pop_front();
          if (got != want) begin
            fail_count++;
            // fields from the top: rd ld rl rs ll ls
            if (fail_count <= 10)
              $display("beat %0d: expected %06b, got %06b (rd ld rl rs ll ls)",
                       beat_no, want, got);
          end
        end
        beat_no++;
      end
    end
    outstanding <= event_q.size();
  end

  initial fail_count = 0;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Two-button debouncer test: a directed run of presses, releases, bounces and
// long holds, then random press sequences with glitches over several timing
// settings (extremes included) and several idle and stall patterns, one of
// them with a long output hold-off. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CNT_W       = 16;
  localparam int          CYCLE_LIMIT = 200000;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [bdslp_pkg::CFG_IDX_W-1:0] cfg_index = bdslp_pkg::CFG_DEBOUNCE_TICKS;
  logic [bdslp_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [bdslp_pkg::S_DATA_W-1:0]  s_tdata = '1;   // left_raw, right_raw, zero pad
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [bdslp_pkg::M_DATA_W-1:0]  m_tdata;        // left_short, left_long, right_short,
                                                   // right_long, left_down, right_down,
                                                   // zero pad
  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int holdoff_req = 0;

  always #5 clk = ~clk;

  button_debounce_short_long_press #(
    .COUNTER_WIDTH(CNT_W)
  ) i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  press_event_checker #(
    .CNT_W(CNT_W)
  ) i_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Drive result ready: random stalls, plus a long hold-off on request
  initial begin
    int holdoff_left;
    holdoff_left = 0;
    forever begin
      @(posedge clk);
      if (holdoff_req != 0) begin
        holdoff_left = holdoff_req;
        holdoff_req  = 0;
      end
      if (holdoff_left > 0) begin
        m_tready <= 1'b0;
        holdoff_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one tick beat and hold it until accepted; raw = {right, left}
  task automatic send_tick(input logic [1:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(bdslp_pkg::S_DATA_W-2){1'b0}}, raw};
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid and wait until every tick has produced its result
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both timing registers on back-to-back cycles
  task automatic load_timing(input logic [bdslp_pkg::CFG_W-1:0] deb,
                             input logic [bdslp_pkg::CFG_W-1:0] lng);
    cfg_we    <= 1'b1;
    cfg_index <= bdslp_pkg::CFG_DEBOUNCE_TICKS;
    cfg_data  <= deb;
    @(posedge clk);
    cfg_index <= bdslp_pkg::CFG_LONG_PRESS_TICKS;
    cfg_data  <= lng;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random press sequences: level runs short and long around the timing
  // settings, with single-tick glitches mixed in
  task automatic random_presses(input int count, input int deb, input int lng);
    logic [1:0] level;
    logic [1:0] raw;
    int run_left [2];
    int short_hi;
    int long_hi;
    int long_lo;
    level    = 2'b11;
    run_left = '{0, 0};
    short_hi = (deb + 2 > 12) ? 12 : deb + 2;
    long_hi  = (deb + lng + 4 > 40) ? 40 : deb + lng + 4;
    long_lo  = (deb + 1 > long_hi) ? long_hi : deb + 1;
    for (int i = 0; i < count; i++) begin
      for (int k = 0; k < 2; k++) begin
        if (run_left[k] == 0) begin
          level[k]    = ~level[k];
          run_left[k] = ($urandom_range(2) == 0) ? $urandom_range(1, short_hi)
                                                 : $urandom_range(long_lo, long_hi);
        end
        run_left[k]--;
      end
      raw = level;
      if ($urandom_range(99) < 6)
        raw[$urandom_range(1)] ^= 1'b1;
      send_tick(raw);
    end
  endtask

  initial begin
    logic [1:0] directed [$];
    directed = '{2'b11, 2'b10, 2'b10, 2'b10, 2'b11, 2'b11,
                 2'b01, 2'b01, 2'b01, 2'b01, 2'b01, 2'b01, 2'b11, 2'b11,
                 2'b00, 2'b11, 2'b00, 2'b11,
                 2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b11, 2'b11};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: short press, long press with no short on release, bounce,
    // both buttons held to a long press together
    load_timing(16'd0, 16'd3);
    foreach (directed[i]) send_tick(directed[i]);
    drain();

    // Random phases over timing settings and idle patterns
    load_timing(16'd1, 16'd4);
    send_idle_pct = 0;  stall_pct = 0;
    random_presses(100, 1, 4);
    drain();

    load_timing(16'd0, 16'd1);
    send_idle_pct = 81; stall_pct = 0;
    random_presses(80, 0, 1);
    drain();

    // zero long time: long press on the tick of the stable press
    load_timing(16'd2, 16'd0);
    send_idle_pct = 0;  stall_pct = 81;
    random_presses(80, 2, 0);
    drain();

    load_timing(16'd3, 16'd6);
    send_idle_pct = 37; stall_pct = 37;
    random_presses(100, 3, 6);
    drain();

    // saturated limits: nothing is ever adopted
    load_timing(16'hFFFF, 16'hFFFF);
    send_idle_pct = 0;  stall_pct = 0;
    random_presses(40, 65535, 65535);
    drain();

    // fast debounce, long press never reached
    load_timing(16'd0, 16'hFFFF);
    send_idle_pct = 37; stall_pct = 37;
    random_presses(40, 0, 65535);
    drain();

    // hold off the output so the block fills and stalls its input
    load_timing(16'd5, 16'd12);
    send_idle_pct = 0;  stall_pct = 0;
    holdoff_req = 150;
    random_presses(80, 5, 12);
    drain();

    load_timing(16'd4, 16'd9);
    send_idle_pct = 37; stall_pct = 37;
    random_presses(60, 4, 9);
    drain();

    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: button_debounce_short_long_press.f
rtl/bdslp_pkg.sv
rtl/bdslp_button.sv
rtl/button_debounce_short_long_press.sv
sim/press_event_checker.sv
sim/tb.sv
